FILE: rtl/trapezoidal_velocity_profile_defines.svh
// ----------------------------------------------------------------------------
// trapezoidal velocity profile assertion macros
// shared assertion wrappers, clocked on the rising edge, off during reset
// ----------------------------------------------------------------------------
`ifndef TRAPEZOIDAL_VELOCITY_PROFILE_DEFINES_SVH
`define TRAPEZOIDAL_VELOCITY_PROFILE_DEFINES_SVH

// property holds at every edge
`define TVP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define TVP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/tvp_pkg.sv
// ----------------------------------------------------------------------------
// tvp_pkg
// widths, register indexes and shared types of the velocity profile block
// ----------------------------------------------------------------------------
package tvp_pkg;

    localparam int DIST_W     = 24;
    localparam int VEL_W      = 24;
    localparam int ACC_W      = 16;
    localparam int PROD_W     = ACC_W + DIST_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int Q_DEPTH    = 2;
    localparam int Q_CNT_W    = 2;

    localparam logic [VEL_W-1:0] VEL_MAX = {VEL_W{1'b1}};

    localparam logic [Q_CNT_W-1:0] Q_CNT_MAX = Q_CNT_W'(Q_DEPTH);

    localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_FLOOR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCELERATION   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DONE_TOLERANCE = 3'd5;

    typedef struct packed {
        logic [DIST_W-1:0] segment_length;
        logic [VEL_W-1:0]  cruise_limit;
        logic [VEL_W-1:0]  speed_floor;
        logic [ACC_W-1:0]  acceleration;
        logic [VEL_W-1:0]  ramp_step;
        logic [DIST_W-1:0] done_tolerance;
    } t_cfg;

    typedef struct packed {
        logic              past_end;
        logic              done;
        logic [PROD_W-1:0] prod;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ROOT,
        BK_EMIT
    } t_back_state;

    typedef struct packed {
        logic pop;
        logic step;
        logic emit;
    } t_back_ctl;

endpackage

FILE: rtl/tvp_if.sv
// ----------------------------------------------------------------------------
// tvp channel interfaces
// valid/ready channels for input beats, result beats and register writes
// ----------------------------------------------------------------------------
interface tvp_in_if;
    logic                       valid;
    logic                       ready;
    logic [tvp_pkg::DIST_W-1:0] travelled;

    modport source (output valid, output travelled, input ready);
    modport sink   (input valid, input travelled, output ready);
endinterface

interface tvp_out_if;
    logic                      valid;
    logic                      ready;
    logic [tvp_pkg::VEL_W-1:0] velocity_setpoint;
    logic                      segment_done;

    modport source (output valid, output velocity_setpoint, output segment_done, input ready);
    modport sink   (input valid, input velocity_setpoint, input segment_done, output ready);
endinterface

interface tvp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tvp_pkg::CFG_IDX_W-1:0]  index;
    logic [tvp_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/tvp_front.sv
// ----------------------------------------------------------------------------
// tvp_front
// takes input beats, flags segment end and done, forms accel times remaining
// ----------------------------------------------------------------------------
module tvp_front (
    input  tvp_pkg::t_cfg i_cfg,
    tvp_in_if.sink        i_in,
    input  logic          i_q_ready,
    output logic          o_push,
    output tvp_pkg::t_job o_job
);

    logic [tvp_pkg::DIST_W:0]   w_reach;
    logic [tvp_pkg::DIST_W-1:0] w_remaining;

    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid & i_q_ready;

    assign w_reach     = {1'b0, i_in.travelled} + {1'b0, i_cfg.done_tolerance};
    assign w_remaining = i_cfg.segment_length - i_in.travelled;

    always_comb begin
        o_job.past_end = (i_in.travelled >= i_cfg.segment_length);
        o_job.done     = (w_reach >= {1'b0, i_cfg.segment_length});
        o_job.prod     = tvp_pkg::PROD_W'(i_cfg.acceleration)
                         * tvp_pkg::PROD_W'(w_remaining);
    end

endmodule

FILE: rtl/tvp_queue.sv
// ----------------------------------------------------------------------------
// tvp_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
`include "trapezoidal_velocity_profile_defines.svh"

module tvp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tvp_pkg::t_job i_job,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output tvp_pkg::t_job o_job
);

    tvp_pkg::t_job                r_slot [tvp_pkg::Q_DEPTH];
    logic                         r_wr_ptr;
    logic                         r_rd_ptr;
    logic [tvp_pkg::Q_CNT_W-1:0]  r_count;
    logic [tvp_pkg::Q_CNT_W-1:0]  n_count;

    assign o_ready = (r_count != tvp_pkg::Q_CNT_MAX);
    assign o_valid = (r_count != '0);
    assign o_job   = r_slot[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    `TVP_ASSERT(a_q_count, i_clk, i_rst_n, r_count <= tvp_pkg::Q_CNT_MAX, "queue count overflow")
    `TVP_ASSERT(a_q_pop, i_clk, i_rst_n, !i_pop || (r_count != '0), "pop from empty queue")

endmodule

FILE: rtl/tvp_back.sv
// ----------------------------------------------------------------------------
// tvp_back
// bit-serial braking root, ramp and limit selection, result register
// ----------------------------------------------------------------------------
`include "trapezoidal_velocity_profile_defines.svh"

module tvp_back #(
    parameter int FRACTION_BITS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vel_clr,
    input  tvp_pkg::t_cfg i_cfg,
    input  logic          i_q_valid,
    input  tvp_pkg::t_job i_q_job,
    output logic          o_q_pop,
    tvp_out_if.source     o_out
);

    localparam int RAD_W   = tvp_pkg::PROD_W + 1 + FRACTION_BITS;
    localparam int ROOT_W  = (RAD_W + 1) / 2;
    localparam int TOP_BIT = 2 * (ROOT_W - 1);
    localparam int VEL_W   = tvp_pkg::VEL_W;

    localparam logic [RAD_W-1:0] BIT_INIT = RAD_W'(1) << TOP_BIT;

    tvp_pkg::t_back_state r_state;
    tvp_pkg::t_back_state n_state;
    tvp_pkg::t_back_ctl   w_ctl;

    logic [RAD_W-1:0] r_x;
    logic [RAD_W-1:0] r_root;
    logic [RAD_W-1:0] r_bit;
    logic             r_past;
    logic             r_done;
    logic [VEL_W-1:0] r_cur_vel;
    logic             r_out_valid;
    logic [VEL_W-1:0] r_out_vel;
    logic             r_out_done;

    logic [RAD_W-1:0] w_trial;
    logic             w_fits;
    logic [VEL_W:0]   w_ramp_sum;
    logic [VEL_W-1:0] w_ramp;
    logic [VEL_W-1:0] w_brake;
    logic [VEL_W-1:0] w_lim;
    logic [VEL_W-1:0] w_vel;
    logic             w_out_free;

    assign w_out_free = !r_out_valid || o_out.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tvp_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    n_state = i_q_job.past_end ? tvp_pkg::BK_EMIT : tvp_pkg::BK_ROOT;
                end
            end
            tvp_pkg::BK_ROOT: begin
                if (r_bit[0]) begin
                    n_state = tvp_pkg::BK_EMIT;
                end
            end
            tvp_pkg::BK_EMIT: begin
                if (w_out_free) begin
                    n_state = tvp_pkg::BK_IDLE;
                end
            end
            default: n_state = tvp_pkg::BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_ctl = '0;
        unique case (r_state)
            tvp_pkg::BK_IDLE: w_ctl.pop  = i_q_valid;
            tvp_pkg::BK_ROOT: w_ctl.step = 1'b1;
            tvp_pkg::BK_EMIT: w_ctl.emit = w_out_free;
            default:          w_ctl      = '0;
        endcase
    end

    assign o_q_pop = w_ctl.pop;

    // one root bit per cycle
    assign w_trial = r_root + r_bit;
    assign w_fits  = (r_x >= w_trial);

    // candidate limits
    assign w_ramp_sum = {1'b0, r_cur_vel} + {1'b0, i_cfg.ramp_step};
    assign w_ramp     = w_ramp_sum[VEL_W] ? tvp_pkg::VEL_MAX : w_ramp_sum[VEL_W-1:0];
    assign w_brake    = (|r_root[RAD_W-1:VEL_W]) ? tvp_pkg::VEL_MAX : r_root[VEL_W-1:0];

    always_comb begin
        w_lim = i_cfg.cruise_limit;
        if (w_ramp < w_lim) begin
            w_lim = w_ramp;
        end
        if (w_brake < w_lim) begin
            w_lim = w_brake;
        end
        if (w_lim < i_cfg.speed_floor) begin
            w_lim = i_cfg.speed_floor;
        end
        w_vel = r_past ? '0 : w_lim;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tvp_pkg::BK_IDLE;
            r_cur_vel   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_vel_clr) begin
                r_cur_vel <= '0;
            end else if (w_ctl.emit) begin
                r_cur_vel <= w_vel;
            end
            if (w_ctl.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.pop) begin
            r_x    <= RAD_W'(i_q_job.prod) << (FRACTION_BITS + 1);
            r_root <= '0;
            r_bit  <= BIT_INIT;
            r_past <= i_q_job.past_end;
            r_done <= i_q_job.done;
        end else if (w_ctl.step) begin
            if (w_fits) begin
                r_x    <= r_x - w_trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (w_ctl.emit) begin
            r_out_vel  <= w_vel;
            r_out_done <= r_done;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.velocity_setpoint = r_out_vel;
    assign o_out.segment_done      = r_out_done;

    `TVP_ASSERT(a_root_bit, i_clk, i_rst_n, (r_state != tvp_pkg::BK_ROOT) || $onehot(r_bit), "root bit lost")
    `TVP_ASSERT_NEXT(a_vel_clr, i_clk, i_rst_n, i_vel_clr, r_cur_vel == '0, "velocity not cleared")
    `TVP_ASSERT_NEXT(a_past_zero, i_clk, i_rst_n, w_ctl.emit && r_past, o_out.velocity_setpoint == '0, "nonzero setpoint past segment end")

endmodule

FILE: rtl/trapezoidal_velocity_profile.sv
// ----------------------------------------------------------------------------
// trapezoidal_velocity_profile
// per-tick velocity setpoint: ramp, cruise and braking limits, raised to floor
// ----------------------------------------------------------------------------
//  channel   dir   beat
//  i_in      in    travelled
//  o_out     out   velocity_setpoint, segment_done
//  i_cfg     in    register index, write data (always ready)
//
//  an item past segment end skips the root and goes straight to emit with a
//  zero setpoint; other items first run the bit-serial root before emit,
//  one root bit per cycle
//  the front takes up to two more beats into its queue while the back works
//  a stalled result holds the back in its emit step until taken
//  synchronous reset clears registers, stored velocity and queue
// ----------------------------------------------------------------------------
module trapezoidal_velocity_profile #(
    parameter int FRACTION_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tvp_in_if.sink     i_in,
    tvp_out_if.source  o_out,
    tvp_cfg_if.sink    i_cfg
);

    tvp_pkg::t_cfg r_cfg;
    tvp_pkg::t_cfg n_cfg;
    logic          w_cfg_wr;
    logic          w_vel_clr;

    logic          w_push;
    logic          w_q_ready;
    tvp_pkg::t_job w_push_job;
    logic          w_q_valid;
    logic          w_q_pop;
    tvp_pkg::t_job w_q_job;

    assign i_cfg.ready = 1'b1;
    assign w_cfg_wr    = i_cfg.valid & i_cfg.ready;

    // register write decode
    always_comb begin
        n_cfg     = r_cfg;
        w_vel_clr = 1'b0;
        if (w_cfg_wr) begin
            unique case (i_cfg.index)
                tvp_pkg::REG_SEGMENT_LENGTH: begin
                    n_cfg.segment_length = i_cfg.data;
                    w_vel_clr            = 1'b1;
                end
                tvp_pkg::REG_CRUISE_LIMIT: begin
                    n_cfg.cruise_limit = i_cfg.data;
                    w_vel_clr          = 1'b1;
                end
                tvp_pkg::REG_SPEED_FLOOR: begin
                    n_cfg.speed_floor = i_cfg.data;
                    w_vel_clr         = 1'b1;
                end
                tvp_pkg::REG_ACCELERATION: begin
                    n_cfg.acceleration = i_cfg.data[tvp_pkg::ACC_W-1:0];
                    w_vel_clr          = 1'b1;
                end
                tvp_pkg::REG_RAMP_STEP: begin
                    n_cfg.ramp_step = i_cfg.data;
                    w_vel_clr       = 1'b1;
                end
                tvp_pkg::REG_DONE_TOLERANCE: begin
                    n_cfg.done_tolerance = i_cfg.data;
                    w_vel_clr            = 1'b1;
                end
                default: w_vel_clr = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    tvp_front u_front (
        .i_cfg     (r_cfg),
        .i_in      (i_in),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_job     (w_push_job)
    );

    tvp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_ready (w_q_ready),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_job   (w_q_job)
    );

    tvp_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vel_clr (w_vel_clr),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_q_job   (w_q_job),
        .o_q_pop   (w_q_pop),
        .o_out     (o_out)
    );

endmodule

FILE: dv/tb_trapezoidal_velocity_profile.sv
// ----------------------------------------------------------------------------
// tb_trapezoidal_velocity_profile
// self-checking bench for the velocity profile block: every accepted travelled
// beat is run through a setpoint predictor kept in the bench, and each result
// beat is compared in order against it, under random source and sink idling,
// one long sink hold-off and a series of register settings
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_trapezoidal_velocity_profile;

    localparam int FRAC_BITS   = 8;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [tvp_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [tvp_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [tvp_pkg::VEL_W-1:0] vel;
        logic                      done;
    } t_setpoint;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tvp_in_if  in_ch ();
    tvp_out_if out_ch ();
    tvp_cfg_if cfg_ch ();

    trapezoidal_velocity_profile #(
        .FRACTION_BITS(FRAC_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    tvp_pkg::t_cfg             prof_cfg;
    logic [tvp_pkg::VEL_W-1:0] stored_vel;
    t_setpoint                 setpoint_q[$];

    int errors      = 0;
    int cycle_cnt   = 0;
    int ticks_sent  = 0;
    bit src_gaps    = 1'b1;
    bit sink_stalls = 1'b1;
    int long_stall  = 0;
    int stall_left  = 0;
    int run_left    = 0;

    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic t_setpoint next_setpoint(input logic [tvp_pkg::DIST_W-1:0] trav);
        t_setpoint   sp;
        logic [63:0] remaining;
        logic [63:0] ramp;
        logic [63:0] brake;
        logic [63:0] v;
        sp.done = (25'(trav) + 25'(prof_cfg.done_tolerance)) >= 25'(prof_cfg.segment_length);
        if (trav >= prof_cfg.segment_length) begin
            stored_vel = '0;
            sp.vel     = '0;
            return sp;
        end
        remaining = 64'(prof_cfg.segment_length) - 64'(trav);
        ramp      = 64'(stored_vel) + 64'(prof_cfg.ramp_step);
        if (ramp > 64'(tvp_pkg::VEL_MAX)) begin
            ramp = 64'(tvp_pkg::VEL_MAX);
        end
        brake = floor_sqrt((64'd2 * 64'(prof_cfg.acceleration) * remaining) << FRAC_BITS);
        v = 64'(prof_cfg.cruise_limit);
        if (ramp < v) begin
            v = ramp;
        end
        if (brake < v) begin
            v = brake;
        end
        if (v < 64'(prof_cfg.speed_floor)) begin
            v = 64'(prof_cfg.speed_floor);
        end
        stored_vel = v[tvp_pkg::VEL_W-1:0];
        sp.vel     = v[tvp_pkg::VEL_W-1:0];
        return sp;
    endfunction

    function automatic void apply_reg(input logic [tvp_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [tvp_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            tvp_pkg::REG_SEGMENT_LENGTH: prof_cfg.segment_length = val;
            tvp_pkg::REG_CRUISE_LIMIT:   prof_cfg.cruise_limit   = val;
            tvp_pkg::REG_SPEED_FLOOR:    prof_cfg.speed_floor    = val;
            tvp_pkg::REG_ACCELERATION:   prof_cfg.acceleration   = val[tvp_pkg::ACC_W-1:0];
            tvp_pkg::REG_RAMP_STEP:      prof_cfg.ramp_step      = val;
            tvp_pkg::REG_DONE_TOLERANCE: prof_cfg.done_tolerance = val;
            default:                     return;
        endcase
        stored_vel = '0;
    endfunction

    function automatic logic [23:0] pick_value(input logic [23:0] typical);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 24'($urandom);
            default: return typical;
        endcase
    endfunction

    task automatic send_travelled(input logic [tvp_pkg::DIST_W-1:0] trav);
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.travelled <= trav;
        do @(posedge i_clk); while (!in_ch.ready);
        setpoint_q.push_back(next_setpoint(trav));
        ticks_sent++;
    endtask

    task automatic write_reg(input logic [tvp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tvp_pkg::CFG_DATA_W-1:0] val,
                             input bit last = 1'b1);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        apply_reg(idx, val);
        if (last) begin
            cfg_ch.valid <= 1'b0;
        end
    endtask

    task automatic settle_idle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (setpoint_q.size() != 0);
    endtask

    task automatic program_profile(input logic [23:0] len, input logic [23:0] cruise,
                                   input logic [23:0] min_vel, input logic [23:0] accel,
                                   input logic [23:0] ramp, input logic [23:0] tol);
        write_reg(tvp_pkg::REG_SEGMENT_LENGTH, len, 1'b0);
        write_reg(tvp_pkg::REG_CRUISE_LIMIT, cruise, 1'b0);
        write_reg(tvp_pkg::REG_SPEED_FLOOR, min_vel, 1'b0);
        write_reg(tvp_pkg::REG_ACCELERATION, accel, 1'b0);
        write_reg(tvp_pkg::REG_RAMP_STEP, ramp, 1'b0);
        write_reg(tvp_pkg::REG_DONE_TOLERANCE, tol);
    endtask

    // all registers at reset value: every tick is past the end
    task automatic test_reset_state();
        send_travelled('0);
        send_travelled('1);
        settle_idle();
    endtask

    // widest settings, ramp saturation, acceleration write masked to 16 bits
    task automatic test_extremes();
        program_profile('1, '1, '0, '1, '1, '0);
        send_travelled('0);
        send_travelled('0);
        send_travelled(24'hFFFFFE);
        send_travelled('1);
        send_travelled(24'h000001);
        settle_idle();
    endtask

    // floor above cruise, zero acceleration, tolerance beyond the length
    task automatic test_floor_and_tolerance();
        program_profile(24'd1000, 24'd100, 24'd500, 24'd0, 24'd10, 24'd2000);
        send_travelled(24'd0);
        send_travelled(24'd999);
        send_travelled(24'd1000);
        send_travelled(24'd500);
        settle_idle();
    endtask

    // spare indexes leave the ramp alone, a real register write restarts it
    task automatic test_write_clears_velocity();
        program_profile(24'h100000, 24'h008000, 24'd0, 24'd100, 24'h001000, 24'd16);
        send_travelled(24'd0);
        send_travelled(24'd256);
        send_travelled(24'd512);
        settle_idle();
        write_reg(REG_SPARE_LO, 24'h000000, 1'b0);
        write_reg(REG_SPARE_HI, 24'hFFFFFF);
        send_travelled(24'd768);
        settle_idle();
        write_reg(tvp_pkg::REG_RAMP_STEP, 24'h001000);
        send_travelled(24'd1024);
        send_travelled(24'h0FFFF0);
        settle_idle();
    endtask

    // sink holds off while the source keeps offering beats
    task automatic test_backpressure();
        src_gaps = 1'b0;
        program_profile(24'h040000, 24'h004000, 24'd32, 24'd500, 24'h000800, 24'd64);
        long_stall = 300;
        for (int k = 0; k < 12; k++) begin
            send_travelled(24'(k * 24'h002000));
        end
        settle_idle();
        src_gaps = 1'b1;
    endtask

    task automatic program_random_profile();
        logic [23:0] cruise;
        bit          spare;
        cruise = pick_value(24'($urandom_range(64, 20000)));
        spare  = ($urandom_range(0, 3) == 0);
        write_reg(tvp_pkg::REG_SEGMENT_LENGTH, pick_value(24'($urandom_range(256, 65536))),
                  1'b0);
        write_reg(tvp_pkg::REG_CRUISE_LIMIT, cruise, 1'b0);
        write_reg(tvp_pkg::REG_SPEED_FLOOR,
                  ($urandom_range(0, 3) == 0) ? pick_value(24'($urandom_range(0, 500))) : '0,
                  1'b0);
        write_reg(tvp_pkg::REG_ACCELERATION, pick_value(24'($urandom_range(1, 4000))), 1'b0);
        write_reg(tvp_pkg::REG_RAMP_STEP, pick_value(cruise / 24'($urandom_range(2, 12))),
                  1'b0);
        write_reg(tvp_pkg::REG_DONE_TOLERANCE, pick_value(24'($urandom_range(0, 1024))),
                  !spare);
        if (spare) begin
            write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 24'($urandom));
        end
    endtask

    // segments with rising travelled, some noise beats mixed in
    task automatic test_random_segments(input int n_items);
        int          n;
        int          ticks;
        int unsigned pos;
        int unsigned stride_max;
        n = 0;
        while (n < n_items) begin
            if (n > n_items - n_items / 8) begin
                src_gaps    = 1'b0;
                sink_stalls = 1'b0;
            end
            settle_idle();
            if ($urandom_range(0, 3) != 0) begin
                program_random_profile();
            end
            ticks      = $urandom_range(8, 40);
            stride_max = 2 * (int'(prof_cfg.segment_length) / ticks) + 1;
            pos        = 0;
            for (int k = 0; k < ticks + 4; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_travelled(24'($urandom));
                end else begin
                    send_travelled(pos[23:0]);
                    pos += $urandom_range(0, stride_max);
                    if (pos > 32'h00FFFFFF) begin
                        pos = 32'h00FFFFFF;
                    end
                end
                n++;
            end
        end
    endtask

    // sink ready: random hold-off bursts and one long requested hold-off
    initial out_ch.ready = 1'b0;

    always @(posedge i_clk) begin
        if (long_stall > 0) begin
            out_ch.ready <= 1'b0;
            long_stall--;
        end else if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end else if (sink_stalls && run_left == 0 && $urandom_range(0, 2) == 0) begin
            out_ch.ready <= 1'b0;
            stall_left = $urandom_range(1, 12) - 1;
            run_left   = $urandom_range(0, 30);
        end else begin
            out_ch.ready <= 1'b1;
            if (run_left > 0) begin
                run_left--;
            end
        end
    end

    // result beat check
    always @(posedge i_clk) begin
        t_setpoint want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (setpoint_q.size() == 0) begin
                $display("%0t unexpected beat: vel %0d done %0d", $time,
                         out_ch.velocity_setpoint, out_ch.segment_done);
                errors++;
            end else begin
                want = setpoint_q.pop_front();
                if (want.vel !== out_ch.velocity_setpoint) begin
                    $display("%0t velocity_setpoint mismatch: expected %0d actual %0d", $time,
                             want.vel, out_ch.velocity_setpoint);
                    errors++;
                end
                if (want.done !== out_ch.segment_done) begin
                    $display("%0t segment_done mismatch: expected %0d actual %0d", $time,
                             want.done, out_ch.segment_done);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.travelled = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = '0;
        prof_cfg        = '0;
        stored_vel      = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_extremes();
        test_floor_and_tolerance();
        test_write_clears_velocity();
        test_backpressure();
        test_random_segments(1400);
        settle_idle();
        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/tvp_pkg.sv
rtl/tvp_if.sv
rtl/tvp_front.sv
rtl/tvp_queue.sv
rtl/tvp_back.sv
rtl/trapezoidal_velocity_profile.sv
dv/tb_trapezoidal_velocity_profile.sv
